// ----- src/assert_macros.svh -----
// Assertion macros shared by the conversion unit.
// Depends on nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that holds even during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- src/dtfp_pkg.sv -----
// Package for the double to fixed-point unit: widths, codes and the conversion function.
// Depends on nothing.
package dtfp_pkg;
    localparam int MAX_INT_BITS  = 16;
    localparam int MAX_FRAC_BITS = 8;
    localparam int TOTAL_LIMIT   = 24;
    localparam int FLOAT_W       = 64;
    localparam int FIXED_W       = 24;
    localparam int CFG_ADDR_W    = 1;
    localparam int CFG_DATA_W    = 32;
    localparam logic [FIXED_W-1:0] ERROR_CODE = 24'd32768;
    localparam logic [CFG_ADDR_W-1:0] REG_INT_BITS  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAC_BITS = 1'b1;
    localparam logic [4:0] RESET_INT_BITS  = 5'd8;
    localparam logic [3:0] RESET_FRAC_BITS = 4'd8;

    typedef struct packed {
        logic [4:0] int_bits;
        logic [3:0] frac_bits;
    } t_format;

    typedef struct packed {
        logic [FIXED_W-1:0] fixed_value;
        logic               range_error;
    } t_result;

    // Converts one binary64 pattern. The result is held in a 25-bit quotient:
    // any value that passes the range check has at most 24 significant integer bits.
    function automatic t_result convert(input logic [FLOAT_W-1:0] bits, input t_format fmt);
        t_result     res;
        logic        neg;
        logic [10:0] ex;
        logic [52:0] man;
        logic signed [12:0] k;
        logic [4:0]  total;
        logic [24:0] bound;
        logic [23:0] mask;
        logic [24:0] q;
        logic        rem;
        logic        err;
        logic [5:0]  sh;
        logic [52:0] shifted;
        logic [52:0] lost;
        res   = '{fixed_value: '0, range_error: 1'b0};
        neg   = bits[63];
        ex    = bits[62:52];
        man   = {(ex != 11'd0), bits[51:0]};
        total = fmt.int_bits + 5'(fmt.frac_bits);
        bound = 25'd1 << (total - 5'd1);
        mask  = 24'((25'd1 << total) - 25'd1);
        k     = (ex == 11'd0) ? -13'sd1074 : (13'($signed({2'b00, ex})) - 13'sd1075);
        k     = k + 13'($signed({1'b0, fmt.frac_bits}));
        err   = 1'b0;
        q     = '0;
        rem   = 1'b0;
        sh    = '0;
        shifted = '0;
        lost  = '0;
        if (k >= 13'sd0) begin
            // Left shift: the mantissa must not exceed the bound shifted right by k.
            if (k >= 13'sd24 || man > 53'(bound >> k[4:0])) begin
                err = 1'b1;
            end else begin
                q = 25'(man << k[4:0]);
            end
        end else if (k < -13'sd63) begin
            q   = '0;
            rem = 1'b1;
        end else begin
            sh      = 6'(-k);
            shifted = man >> sh;
            lost    = man & ((53'd1 << sh) - 53'd1);
            rem     = (lost != '0);
            if (shifted > 53'(bound)) begin
                err = 1'b1;
            end else begin
                q = 25'(shifted);
            end
        end
        if (!neg && q >= bound) err = 1'b1;
        if (neg && (q > bound || (q == bound && rem))) err = 1'b1;
        if (fmt.int_bits < 5'd1 || fmt.int_bits > 5'(MAX_INT_BITS)
                || fmt.frac_bits > 4'(MAX_FRAC_BITS)
                || ({1'b0, fmt.int_bits} + {2'b0, fmt.frac_bits}) > 6'(TOTAL_LIMIT)) begin
            err = 1'b1;
        end
        if (ex == 11'h7FF) err = 1'b1;
        if (err) begin
            res = '{fixed_value: ERROR_CODE, range_error: 1'b1};
        end else if (ex == 11'd0 && bits[51:0] == '0) begin
            res = '{fixed_value: '0, range_error: 1'b0};
        end else if (neg) begin
            res.fixed_value = (24'd0 - 24'(q + {24'd0, rem})) & mask;
        end else begin
            res.fixed_value = 24'(q) & mask;
        end
        return res;
    endfunction
endpackage

// ----- src/dtfp_if.sv -----
// Stream and configuration interfaces for the conversion unit.
// Depends on dtfp_pkg.
interface dtfp_in_if;
    logic valid;
    logic ready;
    logic [dtfp_pkg::FLOAT_W-1:0] float_bits;
    modport source (output valid, output float_bits, input ready);
    modport sink (input valid, input float_bits, output ready);
endinterface

interface dtfp_out_if;
    logic valid;
    logic ready;
    logic [dtfp_pkg::FIXED_W-1:0] fixed_value;
    logic range_error;
    modport source (output valid, output fixed_value, output range_error, input ready);
    modport sink (input valid, input fixed_value, input range_error, output ready);
endinterface

interface dtfp_cfg_if;
    logic valid;
    logic ready;
    logic [dtfp_pkg::CFG_ADDR_W-1:0] index;
    logic [dtfp_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/dtfp_cfg_regs.sv -----
// Format registers for the conversion unit.
// Depends on dtfp_pkg and dtfp_if.
module dtfp_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dtfp_cfg_if.sink      cfg,
    output dtfp_pkg::t_format o_fmt
);
    dtfp_pkg::t_format r_fmt;

    assign cfg.ready = 1'b1;
    assign o_fmt     = r_fmt;

    // Each accepted beat writes one register; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt.int_bits  <= dtfp_pkg::RESET_INT_BITS;
            r_fmt.frac_bits <= dtfp_pkg::RESET_FRAC_BITS;
        end else if (cfg.valid) begin
            case (cfg.index)
                dtfp_pkg::REG_INT_BITS:  r_fmt.int_bits  <= cfg.data[4:0];
                dtfp_pkg::REG_FRAC_BITS: r_fmt.frac_bits <= cfg.data[3:0];
                default: ;
            endcase
        end
    end
endmodule

// ----- src/double_to_fixed_point_unit.sv -----
// Top level of the double to fixed-point unit: input register, conversion, result register.
// Depends on dtfp_pkg, dtfp_if, dtfp_cfg_regs and assert_macros.svh.
// One beat per clock is taken and converted while the output is not stalled. An accepted
// beat is held in the input register, passes the single conversion stage and loads into the
// result register, which offers it on the output. With both registers flowing together, the
// unit sustains one item per cycle while the output is taken.
`include "assert_macros.svh"
module double_to_fixed_point_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtfp_in_if.sink   in_ch,
    dtfp_out_if.source out_ch,
    dtfp_cfg_if.sink  cfg
);
    dtfp_pkg::t_format fmt;
    dtfp_pkg::t_result n_res;
    logic              r_in_valid;
    logic [dtfp_pkg::FLOAT_W-1:0] r_in_bits;
    logic              r_out_valid;
    dtfp_pkg::t_result r_res;
    logic              out_free;
    logic              stage_free;

    dtfp_cfg_regs u_cfg (.i_clk(i_clk), .i_rst_n(i_rst_n), .cfg(cfg), .o_fmt(fmt));

    // Pipeline flow: each stage moves when the one after it is empty or moving.
    assign out_free     = !r_out_valid || out_ch.ready;
    assign stage_free   = !r_in_valid || out_free;
    assign in_ch.ready  = stage_free;
    assign n_res        = dtfp_pkg::convert(r_in_bits, fmt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (stage_free) r_in_valid <= in_ch.valid;
            if (out_free) r_out_valid <= r_in_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (stage_free && in_ch.valid) r_in_bits <= in_ch.float_bits;
        if (out_free && r_in_valid) r_res <= n_res;
    end

    assign out_ch.valid       = r_out_valid;
    assign out_ch.fixed_value = r_res.fixed_value;
    assign out_ch.range_error = r_res.range_error;

    // An error result always carries the error code.
    `ASSERT_IMPL(a_err_code, i_clk, i_rst_n, (r_out_valid && r_res.range_error) |-> (r_res.fixed_value == dtfp_pkg::ERROR_CODE), "error result without error code")
    // A stalled result stays valid on the next cycle.
    `ASSERT_IMPL(a_hold, i_clk, i_rst_n, (r_out_valid && !out_ch.ready) |=> r_out_valid, "stalled result dropped")
    // Reset empties the pipeline.
    `ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> (!r_in_valid && !r_out_valid), "pipeline not empty after reset")
endmodule

// ----- test/dtfp_test_if.sv -----
`timescale 1ns / 100ps
// Test-side note: the block's own interfaces come from src/dtfp_if.sv.
// This file holds the small helper package of test-only constants; it depends on nothing.
package dtfp_test_pkg;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 8;
endpackage

// ----- test/double_to_fixed_point_unit_test.sv -----
`timescale 1ns / 100ps
// Testbench for double_to_fixed_point_unit: directed table, then random doubles under
// several formats, each result checked against a table value or an in-bench conversion model.
// Depends on dtfp_pkg, dtfp_if and dtfp_test_pkg.
module double_to_fixed_point_unit_test;
    import dtfp_pkg::*;
    import dtfp_test_pkg::*;

    typedef struct {
        logic [63:0] bits;
        logic        known;
        logic [23:0] value;
        logic        err;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dtfp_in_if  in_ch ();
    dtfp_out_if out_ch ();
    dtfp_cfg_if cfg ();

    double_to_fixed_point_unit u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state: current format and queue of pending conversions.
    logic [4:0] fmt_int_bits = RESET_INT_BITS;
    logic [3:0] fmt_frac_bits = RESET_FRAC_BITS;
    t_result    pending_results[$];
    int         error_count = 0;
    int         beats_sent = 0;
    int         beats_checked = 0;
    int         idle_cycles = 0;
    bit         long_hold = 1'b0;
    bit         hold_done = 1'b0;

    // Exact floor conversion of one double with wide integer arithmetic.
    function automatic t_result fixed_of_double(logic [63:0] bits);
        t_result      r;
        logic [10:0]  ex;
        logic [52:0]  man;
        int           k;
        int           total;
        logic [63:0]  bound;
        logic [63:0]  q;
        logic         rem;
        r = '{fixed_value: ERROR_CODE, range_error: 1'b1};
        ex = bits[62:52];
        total = fmt_int_bits + fmt_frac_bits;
        if (fmt_int_bits < 1 || fmt_int_bits > MAX_INT_BITS ||
                fmt_frac_bits > MAX_FRAC_BITS || total > TOTAL_LIMIT) return r;
        if (ex == 11'h7FF) return r;
        if (ex == 0 && bits[51:0] == 0) return '{fixed_value: '0, range_error: 1'b0};
        bound = 64'd1 << (total - 1);
        man = {ex != 0, bits[51:0]};
        k = ((ex == 0) ? -1074 : int'(ex) - 1075) + fmt_frac_bits;
        rem = 1'b0;
        if (k >= 0) begin
            if (k >= TOTAL_LIMIT || man > (bound >> k)) return r;
            q = 64'(man) << k;
        end else if (k <= -64) begin
            q = 0;
            rem = 1'b1;
        end else begin
            q = 64'(man >> (-k));
            rem = (man & ((53'd1 << (-k)) - 1)) != 0;
        end
        if (!bits[63]) begin
            if (q >= bound) return r;
        end else begin
            if (q > bound || (q == bound && rem)) return r;
            q = 64'd0 - (q + rem);
        end
        r.fixed_value = 24'(q & ((64'd1 << total) - 1));
        r.range_error = 1'b0;
        return r;
    endfunction

    // Builds a double from sign, unbiased exponent and mantissa.
    function automatic logic [63:0] make_double(bit s, int e, logic [51:0] m);
        return {s, 11'(e + 1023), m};
    endfunction

    // Writes one format register through the configuration channel.
    task automatic write_register(logic [CFG_ADDR_W-1:0] index, logic [31:0] data);
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
        if (index == REG_INT_BITS) fmt_int_bits = data[4:0];
        else fmt_frac_bits = data[3:0];
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    // Sends one double beat, predicting at acceptance. The beat stays offered after
    // acceptance until the next call or the drain lowers valid.
    task automatic send_double(logic [63:0] bits, bit known = 0,
                               t_result want = '{default: '0});
        int gap;
        gap = $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.float_bits <= bits;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(known ? want : fixed_of_double(bits));
        beats_sent++;
    endtask

    // Stops offering beats, waits until every pending result has been checked,
    // then lets the pipe settle.
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Random double biased toward the interesting exponent window.
    function automatic logic [63:0] random_double();
        logic [63:0] b;
        int pick;
        b = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick < 7) b[62:52] = 11'(1023 + $urandom_range(0, 40) - 20);
        else if (pick == 7) b[62:52] = 11'd0;
        else if (pick == 8) b[62:52] = 11'h7FF;
        if ($urandom_range(0, 15) == 0) b[51:0] = '0;
        return b;
    endfunction

    // Receiver: random stalls, one long hold-off, beat checks.
    initial begin
        int wait_cycles;
        t_result want;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (wait_cycles != 0) begin
                out_ch.ready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result fixed=%h err=%b", $time,
                         out_ch.fixed_value, out_ch.range_error);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (want.fixed_value !== out_ch.fixed_value) begin
                    $display("%0t: fixed_value expected %h actual %h", $time,
                             want.fixed_value, out_ch.fixed_value);
                    error_count++;
                end
                if (want.range_error !== out_ch.range_error) begin
                    $display("%0t: range_error expected %b actual %b", $time,
                             want.range_error, out_ch.range_error);
                    error_count++;
                end
            end
            beats_checked++;
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg.valid && cfg.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("double_to_fixed_point_unit_test NOT OK");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        t_row directed_rows[$];
        int formats[][2];
        in_ch.valid = 1'b0;
        in_ch.float_bits = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_INT_BITS;
        cfg.data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows for the reset format Q8.8.
        directed_rows = '{
            '{64'h0000_0000_0000_0000, 1, 24'h0, 0},
            '{64'h8000_0000_0000_0000, 1, 24'h0, 0},
            '{64'h7FF0_0000_0000_0000, 1, ERROR_CODE, 1},
            '{64'hFFF0_0000_0000_0000, 1, ERROR_CODE, 1},
            '{64'h7FF8_0000_0000_0001, 1, ERROR_CODE, 1},
            '{64'hFFFF_FFFF_FFFF_FFFF, 1, ERROR_CODE, 1},
            '{make_double(0, 7, 0), 1, ERROR_CODE, 1},
            '{make_double(1, 7, 0), 1, 24'h8000, 0},
            '{make_double(0, 0, 0), 1, 24'h0100, 0},
            '{make_double(1, 0, 0), 1, 24'hFF00, 0},
            '{64'h8000_0000_0000_0001, 1, 24'hFFFF, 0},
            '{64'h0000_0000_0000_0001, 1, 24'h0, 0},
            '{64'h7FEF_FFFF_FFFF_FFFF, 1, ERROR_CODE, 1},
            '{64'hFFEF_FFFF_FFFF_FFFF, 1, ERROR_CODE, 1},
            '{64'h406F_FFFF_FFFF_FFFF, 0, 24'h0, 0},
            '{64'hC06F_FFFF_FFFF_FFFF, 0, 24'h0, 0},
            '{64'hC060_0000_0000_0001, 0, 24'h0, 0},
            '{64'h3FF8_0000_0000_0000, 0, 24'h0, 0},
            '{64'hBFF8_0000_0000_0000, 0, 24'h0, 0},
            '{64'h5555_5555_5555_5555, 0, 24'h0, 0},
            '{64'h2AAA_AAAA_AAAA_AAAA, 0, 24'h0, 0}
        };
        foreach (directed_rows[i])
            send_double(directed_rows[i].bits, directed_rows[i].known,
                        '{fixed_value: directed_rows[i].value,
                          range_error: directed_rows[i].err});
        drain_results();

        // Formats: extremes, bad ones, ordinary ones.
        formats = '{'{16, 8}, '{1, 0}, '{16, 0}, '{1, 8}, '{0, 4}, '{17, 2},
                    '{31, 15}, '{8, 9}, '{12, 4}, '{3, 5}, '{8, 8}};
        foreach (formats[f]) begin
            write_register(REG_INT_BITS, 32'(formats[f][0]));
            write_register(REG_FRAC_BITS, 32'(formats[f][1]));
            for (int n = 0; n < 100; n++) begin
                if (f == 2 && n == 50) long_hold = 1'b1;
                send_double(random_double());
            end
            drain_results();
        end

        $display("Ran %0d doubles over %0d formats, %0d results checked.",
                 beats_sent, formats.size() + 1, beats_checked);
        if (error_count == 0) begin
            $display("double_to_fixed_point_unit_test OK");
        end else begin
            $display("double_to_fixed_point_unit_test NOT OK");
        end
        $finish;
    end
endmodule
